// ===== sv/uv_sphere_mesh_generator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the UV sphere mesh generator
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_GENERATOR_CORE_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication
`define USM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define USM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/usm_pkg.sv =====
// ----------------------------------------------------------------------------
// usm_pkg
// Shared constants, codes and types of the UV sphere mesh generator.
// ----------------------------------------------------------------------------
package usm_pkg;

	// Pipeline layout: stage 0 input, 1..4 divide, 5..21 trig, 22..23 scale
	localparam int unsigned PIPE_DEPTH  = 24;
	localparam int unsigned DIV_FIRST   = 1;
	localparam int unsigned DIV_STAGES  = 4;
	localparam int unsigned QUO_BITS    = 16;
	localparam int unsigned TRIG_FIRST  = DIV_FIRST + DIV_STAGES;
	localparam int unsigned TERMS       = 7;
	localparam int unsigned TRIG_STAGES = 2 * TERMS + 3;
	localparam int unsigned MUL_STAGE   = TRIG_FIRST + TRIG_STAGES;
	localparam int unsigned RND_STAGE   = MUL_STAGE + 1;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

	// Taylor term divisors and reciprocal shifts (33 + ceil(log2(div)))
	localparam int unsigned SIN_DIV   [TERMS] = '{6, 20, 42, 72, 110, 156, 210};
	localparam int unsigned SIN_SHIFT [TERMS] = '{36, 38, 39, 40, 40, 41, 41};
	localparam int unsigned COS_DIV   [TERMS] = '{2, 12, 30, 56, 90, 132, 182};
	localparam int unsigned COS_SHIFT [TERMS] = '{34, 37, 38, 39, 40, 41, 41};

	localparam logic       REG_SLICE_COUNT = 1'b0;
	localparam logic       REG_STACK_COUNT = 1'b1;
	localparam logic [7:0] SLICE_RESET     = 8'd32;
	localparam logic [7:0] STACK_RESET     = 8'd16;

	typedef enum logic [1:0] {
		KIND_VERTEX   = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        tri_first;
		logic        tri_second;
		logic [15:0] corner_a;
		logic [15:0] corner_b;
	} ctl_t;

	typedef struct packed {
		logic signed [19:0] sin_v;
		logic signed [19:0] cos_v;
	} trig_t;

endpackage

// ===== sv/usm_in_if.sv =====
// ----------------------------------------------------------------------------
// usm_in_if
// Input item channel: grid point or quad request.
// ----------------------------------------------------------------------------
interface usm_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] row;
	logic [7:0] col;

	modport source(output valid, output mode, output row, output col, input ready);
	modport sink(input valid, input mode, input row, input col, output ready);
endinterface

// ===== sv/usm_out_if.sv =====
// ----------------------------------------------------------------------------
// usm_out_if
// Result channel: vertex, triangle or error.
// ----------------------------------------------------------------------------
interface usm_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic signed [7:0]  norm_x;
	logic signed [7:0]  norm_y;
	logic signed [7:0]  norm_z;
	logic [15:0]        corner_first;
	logic [15:0]        corner_second;
	logic [15:0]        corner_third;
	logic               last;

	modport source(output valid, output kind, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_y, output norm_z, output corner_first,
		output corner_second, output corner_third, output last, input ready);
	modport sink(input valid, input kind, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_y, input norm_z, input corner_first,
		input corner_second, input corner_third, input last, output ready);
endinterface

// ===== sv/usm_div.sv =====
// ----------------------------------------------------------------------------
// usm_div
// Pipelined restoring divider: floor(num * 2^16 / den), four bits per stage.
// ----------------------------------------------------------------------------
module usm_div (
	input  logic                            clk,
	input  logic [usm_pkg::DIV_STAGES-1:0]  en,
	input  logic [7:0]                      num,
	input  logic [7:0]                      den,
	output logic [16:0]                     quo
);
	localparam int unsigned STEPS = usm_pkg::QUO_BITS / usm_pkg::DIV_STAGES;

	logic [7:0]  rem_s [usm_pkg::DIV_STAGES];
	logic [16:0] quo_s [usm_pkg::DIV_STAGES];
	logic        hi;
	logic [7:0]  rem_init;

	// num == den gives the full-turn quotient bit
	assign hi       = num >= den;
	assign rem_init = hi ? num - den : num;

	for (genvar g = 0; g < usm_pkg::DIV_STAGES; g++) begin : g_stage
		logic [7:0]  rem_in;
		logic [16:0] quo_in;
		logic [7:0]  rem_nx;
		logic [16:0] quo_nx;

		if (g == 0) begin : g_first
			assign rem_in = rem_init;
			assign quo_in = {16'd0, hi};
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign quo_in = quo_s[g-1];
		end

		always_comb begin
			logic [8:0] t;
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int i = 0; i < STEPS; i++) begin
				t = {rem_nx, 1'b0};
				if (t >= {1'b0, den}) begin
					t      = t - {1'b0, den};
					quo_nx = {quo_nx[15:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[15:0], 1'b0};
				end
				rem_nx = t[7:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g] <= rem_nx;
				quo_s[g] <= quo_nx;
			end
		end
	end

	assign quo = quo_s[usm_pkg::DIV_STAGES-1];
endmodule

// ===== sv/usm_trig.sv =====
// ----------------------------------------------------------------------------
// usm_trig
// Pipelined Q30 Taylor sine and cosine of a 17-bit phase, result in Q18.
// ----------------------------------------------------------------------------
module usm_trig (
	input  logic                            clk,
	input  logic [usm_pkg::TRIG_STAGES-1:0] en,
	input  logic [16:0]                     phase,
	output usm_pkg::trig_t                  res
);
	typedef struct packed {
		logic [1:0]         quad;
		logic [31:0]        a2;
		logic [31:0]        ts;
		logic [31:0]        tc;
		logic signed [34:0] s;
		logic signed [34:0] c;
	} term_t;

	typedef struct packed {
		logic [1:0]         quad;
		logic [31:0]        a2;
		logic [63:0]        ps;
		logic [63:0]        pc;
		logic signed [34:0] s;
		logic signed [34:0] c;
	} prod_t;

	logic [1:0]  quad_s0;
	logic [30:0] a_s0;
	logic [45:0] a_prod;
	logic [61:0] sq_prod;
	term_t       term_s [usm_pkg::TERMS+1];
	prod_t       prod_s [usm_pkg::TERMS];

	function automatic logic [18:0] clamp_round(input logic signed [34:0] v);
		logic [30:0] m;
		logic [31:0] t;
		if (v < 0) begin
			m = 31'd0;
		end else if (v > $signed({4'd0, usm_pkg::ONE_Q30})) begin
			m = usm_pkg::ONE_Q30;
		end else begin
			m = v[30:0];
		end
		t = 32'(m) + 32'd2048;
		return t[30:12];
	endfunction

	assign a_prod  = 46'(phase[14:0]) * 46'(usm_pkg::HALF_PI_Q30);
	assign sq_prod = 62'(a_s0) * 62'(a_s0);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			quad_s0 <= phase[16:15];
			a_s0    <= a_prod[45:15];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			term_s[0].quad <= quad_s0;
			term_s[0].a2   <= sq_prod[61:30];
			term_s[0].ts   <= {1'b0, a_s0};
			term_s[0].tc   <= {1'b0, usm_pkg::ONE_Q30};
			term_s[0].s    <= $signed({4'd0, a_s0});
			term_s[0].c    <= $signed({4'd0, usm_pkg::ONE_Q30});
		end
	end

	for (genvar k = 0; k < usm_pkg::TERMS; k++) begin : g_term
		localparam int unsigned SSH  = usm_pkg::SIN_SHIFT[k];
		localparam int unsigned CSH  = usm_pkg::COS_SHIFT[k];
		localparam logic [63:0] SDIV = 64'(usm_pkg::SIN_DIV[k]);
		localparam logic [63:0] CDIV = 64'(usm_pkg::COS_DIV[k]);
		localparam logic [34:0] SREC = 35'(((64'd1 << SSH) + SDIV - 64'd1) / SDIV);
		localparam logic [34:0] CREC = 35'(((64'd1 << CSH) + CDIV - 64'd1) / CDIV);
		localparam bit          SUB  = (k % 2) == 0;

		logic [63:0]        ps_n;
		logic [63:0]        pc_n;
		logic [67:0]        sq;
		logic [67:0]        cq;
		logic [31:0]        ts_n;
		logic [31:0]        tc_n;
		logic signed [34:0] s_n;
		logic signed [34:0] c_n;

		assign ps_n = 64'(term_s[k].ts) * 64'(term_s[k].a2);
		assign pc_n = 64'(term_s[k].tc) * 64'(term_s[k].a2);

		always_ff @(posedge clk) begin
			if (en[2+2*k]) begin
				prod_s[k].quad <= term_s[k].quad;
				prod_s[k].a2   <= term_s[k].a2;
				prod_s[k].ps   <= ps_n;
				prod_s[k].pc   <= pc_n;
				prod_s[k].s    <= term_s[k].s;
				prod_s[k].c    <= term_s[k].c;
			end
		end

		// divide by the factorial factors through an exact reciprocal
		assign sq   = 68'(prod_s[k].ps[62:30]) * 68'(SREC);
		assign cq   = 68'(prod_s[k].pc[62:30]) * 68'(CREC);
		assign ts_n = 32'(sq >> SSH);
		assign tc_n = 32'(cq >> CSH);
		assign s_n  = SUB ? prod_s[k].s - $signed({3'd0, ts_n})
			: prod_s[k].s + $signed({3'd0, ts_n});
		assign c_n  = SUB ? prod_s[k].c - $signed({3'd0, tc_n})
			: prod_s[k].c + $signed({3'd0, tc_n});

		always_ff @(posedge clk) begin
			if (en[3+2*k]) begin
				term_s[k+1].quad <= prod_s[k].quad;
				term_s[k+1].a2   <= prod_s[k].a2;
				term_s[k+1].ts   <= ts_n;
				term_s[k+1].tc   <= tc_n;
				term_s[k+1].s    <= s_n;
				term_s[k+1].c    <= c_n;
			end
		end
	end

	logic signed [19:0] sv;
	logic signed [19:0] cv;
	usm_pkg::trig_t     res_n;

	assign sv = $signed({1'b0, clamp_round(term_s[usm_pkg::TERMS].s)});
	assign cv = $signed({1'b0, clamp_round(term_s[usm_pkg::TERMS].c)});

	// fold the first-quadrant values into the full turn
	always_comb begin
		unique case (term_s[usm_pkg::TERMS].quad)
			2'd0: begin res_n.sin_v = sv;  res_n.cos_v = cv;  end
			2'd1: begin res_n.sin_v = cv;  res_n.cos_v = -sv; end
			2'd2: begin res_n.sin_v = -sv; res_n.cos_v = -cv; end
			default: begin res_n.sin_v = -cv; res_n.cos_v = sv; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[usm_pkg::TRIG_STAGES-1]) begin
			res <= res_n;
		end
	end
endmodule

// ===== sv/uv_sphere_mesh_generator_core.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator_core
// Throughput: one item per cycle unless result.ready is low or a quad holds the
// output, through a 24-stage pipeline (divider, Taylor trig, scaling); a quad with
// two triangles holds the output register for two transactions.
// Reset clears all valid bits and loads slice_count 32 and stack_count 16.
// ----------------------------------------------------------------------------
`include "uv_sphere_mesh_generator_core_assert.svh"

module uv_sphere_mesh_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	usm_in_if.sink      item,
	usm_out_if.source   result
);
	localparam int unsigned D = usm_pkg::PIPE_DEPTH;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [7:0]  norm_x;
		logic signed [7:0]  norm_y;
		logic signed [7:0]  norm_z;
	} res_t;

	logic [7:0]       slice_q;
	logic [7:0]       stack_q;
	logic [D:0]       en;
	logic             vld_s [D];
	usm_pkg::ctl_t    ctl_s [D];
	logic [7:0]       row_s0;
	logic [7:0]       col_s0;
	usm_pkg::ctl_t    ctl_n;
	logic [16:0]      quo_phi;
	logic [16:0]      quo_th;
	usm_pkg::trig_t   trig_phi;
	usm_pkg::trig_t   trig_th;
	logic signed [39:0] x_s22;
	logic signed [39:0] z_s22;
	logic signed [19:0] cp_s22;
	res_t             res_n;
	res_t             res_s23;

	logic             out_v_q;
	logic             pend_q;
	logic             out_load;
	logic             out_take;
	logic [1:0]       kind_q;
	res_t             res_q;
	logic [15:0]      cf_q;
	logic [15:0]      cs_q;
	logic [15:0]      ct_q;
	logic             last_q;
	logic [15:0]      ca_q;
	logic [15:0]      cb_q;

	function automatic logic signed [47:0] round_away(input logic signed [47:0] v,
		input int unsigned sh);
		logic [47:0] m;
		logic [47:0] r;
		m = (v < 0) ? 48'(-v) : 48'(v);
		r = (m + (48'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -$signed(r) : $signed(r);
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= usm_pkg::SLICE_RESET;
			stack_q <= usm_pkg::STACK_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				usm_pkg::REG_SLICE_COUNT: slice_q <= wr_data;
				usm_pkg::REG_STACK_COUNT: stack_q <= wr_data;
				default: ;
			endcase
		end
	end

	// stage enables: a stage advances when empty or when the next one advances
	always_comb begin
		en[D] = out_load;
		for (int j = D - 1; j >= 0; j--) begin
			en[j] = !vld_s[j] || en[j+1];
		end
	end

	assign item.ready = en[0];

	// classify the item and work out the quad corners
	always_comb begin
		logic        ok;
		logic [8:0]  ring;
		logic [16:0] a17;
		logic [16:0] b17;
		ok   = slice_q >= 8'd3 && stack_q >= 8'd2;
		ring = {1'b0, slice_q} + 9'd1;
		a17  = 17'(item.row) * 17'(ring) + 17'(item.col);
		b17  = a17 + 17'(ring);
		if (item.mode) begin
			ok = ok && item.row < stack_q && item.col < slice_q;
		end else begin
			ok = ok && item.row <= stack_q && item.col <= slice_q;
		end
		if (!ok) begin
			ctl_n.kind = usm_pkg::KIND_ERROR;
		end else if (item.mode) begin
			ctl_n.kind = usm_pkg::KIND_TRIANGLE;
		end else begin
			ctl_n.kind = usm_pkg::KIND_VERTEX;
		end
		ctl_n.tri_first  = item.row != 8'd0;
		ctl_n.tri_second = (9'(item.row) + 9'd1) < 9'(stack_q);
		ctl_n.corner_a   = a17[15:0];
		ctl_n.corner_b   = b17[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < D; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				vld_s[0] <= item.valid;
			end
			for (int j = 1; j < D; j++) begin
				if (en[j]) begin
					vld_s[j] <= vld_s[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ctl_s[0] <= ctl_n;
			row_s0   <= item.row;
			col_s0   <= item.col;
		end
		for (int j = 1; j < D; j++) begin
			if (en[j]) begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end
	end

	usm_div u_div_phi (
		.clk (clk),
		.en  (en[usm_pkg::TRIG_FIRST-1:usm_pkg::DIV_FIRST]),
		.num (row_s0),
		.den (stack_q),
		.quo (quo_phi)
	);

	usm_div u_div_th (
		.clk (clk),
		.en  (en[usm_pkg::TRIG_FIRST-1:usm_pkg::DIV_FIRST]),
		.num (col_s0),
		.den (slice_q),
		.quo (quo_th)
	);

	usm_trig u_trig_phi (
		.clk   (clk),
		.en    (en[usm_pkg::MUL_STAGE-1:usm_pkg::TRIG_FIRST]),
		.phase (quo_phi),
		.res   (trig_phi)
	);

	// longitude phase is doubled and wraps at a full turn
	usm_trig u_trig_th (
		.clk   (clk),
		.en    (en[usm_pkg::MUL_STAGE-1:usm_pkg::TRIG_FIRST]),
		.phase ({quo_th[15:0], 1'b0}),
		.res   (trig_th)
	);

	always_ff @(posedge clk) begin
		if (en[usm_pkg::MUL_STAGE]) begin
			x_s22  <= trig_phi.sin_v * trig_th.cos_v;
			z_s22  <= trig_phi.sin_v * trig_th.sin_v;
			cp_s22 <= trig_phi.cos_v;
		end
	end

	always_comb begin
		logic signed [47:0] xw;
		logic signed [47:0] zw;
		logic signed [47:0] cw;
		xw = 48'(x_s22);
		zw = 48'(z_s22);
		cw = 48'(cp_s22);
		res_n.pos_x  = 16'(round_away(xw, 22));
		res_n.pos_y  = 16'(round_away(cw, 4));
		res_n.pos_z  = 16'(round_away(zw, 22));
		res_n.norm_x = 8'(round_away((xw <<< 7) - xw, 36));
		res_n.norm_y = 8'(round_away((cw <<< 7) - cw, 18));
		res_n.norm_z = 8'(round_away((zw <<< 7) - zw, 36));
		if (ctl_s[usm_pkg::MUL_STAGE].kind != usm_pkg::KIND_VERTEX) begin
			res_n = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[usm_pkg::RND_STAGE]) begin
			res_s23 <= res_n;
		end
	end

	// output register; a two-triangle quad stays for a second transaction
	assign out_take = out_v_q && result.ready;
	assign out_load = !out_v_q || (result.ready && !pend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (out_load) begin
			out_v_q <= vld_s[D-1];
			pend_q  <= vld_s[D-1] && ctl_s[D-1].kind == usm_pkg::KIND_TRIANGLE
				&& ctl_s[D-1].tri_first && ctl_s[D-1].tri_second;
		end else if (out_take) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= ctl_s[D-1].kind;
			res_q  <= res_s23;
			ca_q   <= ctl_s[D-1].corner_a;
			cb_q   <= ctl_s[D-1].corner_b;
			if (ctl_s[D-1].kind != usm_pkg::KIND_TRIANGLE) begin
				cf_q   <= 16'd0;
				cs_q   <= 16'd0;
				ct_q   <= 16'd0;
				last_q <= 1'b1;
			end else if (ctl_s[D-1].tri_first) begin
				cf_q   <= ctl_s[D-1].corner_a;
				cs_q   <= ctl_s[D-1].corner_b;
				ct_q   <= ctl_s[D-1].corner_a + 16'd1;
				last_q <= !ctl_s[D-1].tri_second;
			end else begin
				cf_q   <= ctl_s[D-1].corner_a + 16'd1;
				cs_q   <= ctl_s[D-1].corner_b;
				ct_q   <= ctl_s[D-1].corner_b + 16'd1;
				last_q <= 1'b1;
			end
		end else if (out_take) begin
			// advance to the second triangle of the quad
			cf_q   <= ca_q + 16'd1;
			cs_q   <= cb_q;
			ct_q   <= cb_q + 16'd1;
			last_q <= 1'b1;
		end
	end

	assign result.valid         = out_v_q;
	assign result.kind          = kind_q;
	assign result.pos_x         = res_q.pos_x;
	assign result.pos_y         = res_q.pos_y;
	assign result.pos_z         = res_q.pos_z;
	assign result.norm_x        = res_q.norm_x;
	assign result.norm_y        = res_q.norm_y;
	assign result.norm_z        = res_q.norm_z;
	assign result.corner_first  = cf_q;
	assign result.corner_second = cs_q;
	assign result.corner_third  = ct_q;
	assign result.last          = last_q;

	`USM_ASSERT_NOW(a_pend_tri, pend_q, out_v_q && kind_q == usm_pkg::KIND_TRIANGLE && !last_q, "pending second triangle without a first")
	`USM_ASSERT_NEXT(a_second_last, out_take && pend_q, out_v_q && !pend_q && last_q, "second triangle not presented as last")
	`USM_ASSERT_NOW(a_single_last, out_v_q && kind_q != usm_pkg::KIND_TRIANGLE, last_q, "vertex or error result without last")
	`USM_ASSERT_NEXT(a_accept_vld, item.valid && item.ready, vld_s[0], "accepted transaction lost at stage 0")
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UV sphere mesh generator core. It drives
// vertex and quad requests under several grid sizes, predicts every vertex,
// triangle and error transaction, and compares results in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam longint unsigned HALF_PI  = 64'd1686629713;
	localparam longint          UNIT_Q30 = 64'sd1 << 30;

	typedef struct packed {
		usm_pkg::kind_t     kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [7:0]  norm_x;
		logic signed [7:0]  norm_y;
		logic signed [7:0]  norm_z;
		logic [15:0]        corner_first;
		logic [15:0]        corner_second;
		logic [15:0]        corner_third;
		logic               last;
	} mesh_out_t;

	typedef struct {
		logic           mode;
		logic [7:0]     row;
		logic [7:0]     col;
		bit             typed;
		usm_pkg::kind_t kind;
		logic [15:0]    pos_y;
		logic [7:0]     norm_y;
	} grid_req_t;

	logic       clk;
	logic       arst_n;
	logic       wr_en;
	logic       wr_index;
	logic [7:0] wr_data;

	usm_in_if  item_ch();
	usm_out_if result_ch();

	uv_sphere_mesh_generator_core u_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .item(item_ch.sink), .result(result_ch.source)
	);

	logic [7:0]  slices;
	logic [7:0]  stacks;
	mesh_out_t   pending_mesh[$];
	int unsigned accepted;
	int unsigned mismatches;
	int unsigned cycles;
	bit          quiet;

	grid_req_t directed[] = '{
		'{1'b0, 8'd0,   8'd0,   1, usm_pkg::KIND_VERTEX, 16'sd16384,  8'sd127},
		'{1'b0, 8'd16,  8'd0,   1, usm_pkg::KIND_VERTEX, -16'sd16384, -8'sd127},
		'{1'b0, 8'd16,  8'd32,  0, usm_pkg::KIND_VERTEX, 16'd0, 8'd0},
		'{1'b0, 8'd8,   8'd8,   0, usm_pkg::KIND_VERTEX, 16'd0, 8'd0},
		'{1'b0, 8'd8,   8'd16,  0, usm_pkg::KIND_VERTEX, 16'd0, 8'd0},
		'{1'b0, 8'd3,   8'd27,  0, usm_pkg::KIND_VERTEX, 16'd0, 8'd0},
		'{1'b0, 8'd17,  8'd0,   1, usm_pkg::KIND_ERROR,  16'd0, 8'd0},
		'{1'b0, 8'd0,   8'd33,  1, usm_pkg::KIND_ERROR,  16'd0, 8'd0},
		'{1'b0, 8'd255, 8'd255, 1, usm_pkg::KIND_ERROR,  16'd0, 8'd0},
		'{1'b1, 8'd0,   8'd0,   0, usm_pkg::KIND_TRIANGLE, 16'd0, 8'd0},
		'{1'b1, 8'd15,  8'd31,  0, usm_pkg::KIND_TRIANGLE, 16'd0, 8'd0},
		'{1'b1, 8'd7,   8'd5,   0, usm_pkg::KIND_TRIANGLE, 16'd0, 8'd0},
		'{1'b1, 8'd16,  8'd0,   1, usm_pkg::KIND_ERROR,  16'd0, 8'd0},
		'{1'b1, 8'd0,   8'd32,  1, usm_pkg::KIND_ERROR,  16'd0, 8'd0},
		'{1'b1, 8'd255, 8'd255, 1, usm_pkg::KIND_ERROR,  16'd0, 8'd0}
	};

	function automatic longint round_away(input longint v, input int sh);
		longint unsigned m;
		m = v < 0 ? -v : v;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint round_q18(input longint v);
		if (v < 0) v = 0;
		if (v > UNIT_Q30) v = UNIT_Q30;
		return (v + 2048) >>> 12;
	endfunction

	// Taylor series on a quarter turn, then fold by quadrant (Q18 outputs)
	task automatic sin_cos(input logic [16:0] phase, output longint s_q18, output longint c_q18);
		longint unsigned a, a2, ts, tc;
		longint          s, c, sv, cv;
		a  = (longint'(phase[14:0]) * HALF_PI) >> 15;
		a2 = (a * a) >> 30;
		ts = a;
		tc = UNIT_Q30;
		s  = a;
		c  = UNIT_Q30;
		for (int k = 1; k <= 7; k++) begin
			ts = ((ts * a2) >> 30) / ((2 * k) * (2 * k + 1));
			tc = ((tc * a2) >> 30) / ((2 * k - 1) * (2 * k));
			if (k % 2) begin
				s -= ts;
				c -= tc;
			end else begin
				s += ts;
				c += tc;
			end
		end
		sv = round_q18(s);
		cv = round_q18(c);
		case (phase[16:15])
			2'd0: begin s_q18 = sv;  c_q18 = cv;  end
			2'd1: begin s_q18 = cv;  c_q18 = -sv; end
			2'd2: begin s_q18 = -sv; c_q18 = -cv; end
			default: begin s_q18 = -cv; c_q18 = sv; end
		endcase
	endtask

	task automatic predict_mesh(input logic mode, input logic [7:0] row, input logic [7:0] col);
		mesh_out_t       res;
		bit              ok;
		int unsigned     pphi, pth, a, b;
		longint          sp, cp, st, ct, x, z;
		res = '0;
		ok = slices >= 3 && stacks >= 2;
		if (ok) ok = mode ? (row < stacks && col < slices) : (row <= stacks && col <= slices);
		if (!ok) begin
			res.kind = usm_pkg::KIND_ERROR;
			res.last = 1'b1;
			pending_mesh.push_back(res);
		end else if (!mode) begin
			pphi = (int'(row) << 16) / stacks;
			pth  = (((int'(col) << 16) / slices) << 1) & 32'h1FFFF;
			sin_cos(pphi[16:0], sp, cp);
			sin_cos(pth[16:0], st, ct);
			x = sp * ct;
			z = sp * st;
			res.kind   = usm_pkg::KIND_VERTEX;
			res.pos_x  = 16'(round_away(x, 22));
			res.pos_y  = 16'(round_away(cp, 4));
			res.pos_z  = 16'(round_away(z, 22));
			res.norm_x = 8'(round_away(x * 127, 36));
			res.norm_y = 8'(round_away(cp * 127, 18));
			res.norm_z = 8'(round_away(z * 127, 36));
			res.last   = 1'b1;
			pending_mesh.push_back(res);
		end else begin
			a = row * (slices + 1) + col;
			b = a + slices + 1;
			res.kind = usm_pkg::KIND_TRIANGLE;
			if (row > 0) begin
				res.corner_first  = 16'(a);
				res.corner_second = 16'(b);
				res.corner_third  = 16'(a + 1);
				res.last = !(row + 1 < stacks);
				pending_mesh.push_back(res);
			end
			if (row + 1 < stacks) begin
				res.corner_first  = 16'(a + 1);
				res.corner_second = 16'(b);
				res.corner_third  = 16'(b + 1);
				res.last = 1'b1;
				pending_mesh.push_back(res);
			end
		end
	endtask

	// Offer one request, hold it until the transaction completes
	task automatic send_item(input grid_req_t req);
		mesh_out_t res;
		while (!quiet && $urandom_range(99) < 23) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode  <= req.mode;
		item_ch.row   <= req.row;
		item_ch.col   <= req.col;
		do @(posedge clk); while (!item_ch.ready);
		accepted++;
		if (req.typed) begin
			res = '0;
			res.kind   = req.kind;
			res.pos_y  = req.pos_y;
			res.norm_y = req.norm_y;
			res.last   = 1'b1;
			pending_mesh.push_back(res);
		end else begin
			predict_mesh(req.mode, req.row, req.col);
		end
	endtask

	task automatic send_random(input int unsigned count);
		grid_req_t req;
		repeat (count) begin
			req = '{1'b0, 8'd0, 8'd0, 0, usm_pkg::KIND_VERTEX, 16'd0, 8'd0};
			req.mode = 1'($urandom_range(1));
			if ($urandom_range(99) < 85 && stacks >= 2 && slices >= 3) begin
				req.row = 8'($urandom_range(req.mode ? stacks - 1 : stacks));
				req.col = 8'($urandom_range(req.mode ? slices - 1 : slices));
			end else begin
				req.row = 8'($urandom_range(255));
				req.col = 8'($urandom_range(255));
			end
			send_item(req);
		end
	endtask

	// Drain, let the pipeline empty, then load both counts
	task automatic set_grid(input logic [7:0] new_slices, input logic [7:0] new_stacks);
		item_ch.valid <= 1'b0;
		while (pending_mesh.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= usm_pkg::REG_SLICE_COUNT;
		wr_data  <= new_slices;
		@(posedge clk);
		wr_index <= usm_pkg::REG_STACK_COUNT;
		wr_data  <= new_stacks;
		@(posedge clk);
		wr_en  <= 1'b0;
		slices = new_slices;
		stacks = new_stacks;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Result side: check each transaction, then pick the next ready
	initial begin
		mesh_out_t got;
		mesh_out_t want;
		int unsigned hold_left;
		bit          held;
		hold_left = 0;
		held = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got = '{usm_pkg::kind_t'(result_ch.kind), result_ch.pos_x, result_ch.pos_y,
					result_ch.pos_z, result_ch.norm_x, result_ch.norm_y, result_ch.norm_z,
					result_ch.corner_first, result_ch.corner_second,
					result_ch.corner_third, result_ch.last};
				if (pending_mesh.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", got);
				end else begin
					want = pending_mesh.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, actual %p", want, got);
					end
				end
			end
			if (!held && accepted >= 60) begin
				held = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= quiet || $urandom_range(99) >= 23;
			end
		end
	end

	initial begin
		int unsigned wait_cycles;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = usm_pkg::REG_SLICE_COUNT;
		wr_data = 8'd0;
		item_ch.valid = 1'b0;
		item_ch.mode = 1'b0;
		item_ch.row = 8'd0;
		item_ch.col = 8'd0;
		accepted = 0;
		mismatches = 0;
		quiet = 0;
		slices = usm_pkg::SLICE_RESET;
		stacks = usm_pkg::STACK_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_item(directed[i]);
		send_random(130);
		quiet = 1;
		send_random(60);
		quiet = 0;
		set_grid(8'd3, 8'd2);
		send_random(70);
		set_grid(8'd255, 8'd255);
		send_random(80);
		set_grid(8'd2, 8'd1);
		send_random(15);
		set_grid(8'd0, 8'd0);
		send_random(10);
		set_grid(8'($urandom_range(3, 255)), 8'($urandom_range(2, 255)));
		send_random(50);
		set_grid(8'd5, 8'd3);
		send_random(35);

		item_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (pending_mesh.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_mesh.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/usm_pkg.sv
sv/usm_in_if.sv
sv/usm_out_if.sv
sv/usm_div.sv
sv/usm_trig.sv
sv/uv_sphere_mesh_generator_core.sv
dv/testbench.sv
